FILE: rtl/cdfts_pkg.sv
// Shared types and constants for the CDF table size sampler.
// No dependencies; imported by every module of the block.
package cdfts_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam int IDX_W   = 10;
    localparam int SIZE_W  = 24;
    localparam int PROB_W  = 33;
    localparam int CNT_W   = 11;
    localparam int BPP_W   = 16;
    localparam int MSG_W   = 31;
    localparam int PROD_W  = SIZE_W + BPP_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(1500);
    localparam logic [MSG_W-1:0] MSG_MAX   = '1;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRIES_IN_USE   = 2'd0,
        CFG_SCALE_BY_PACKET  = 2'd1,
        CFG_BYTES_PER_PACKET = 2'd2,
        CFG_UNUSED           = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_FETCH,
        ST_MUL
    } state_t;

    // Sequencer commands to the scaling stage
    typedef struct packed {
        logic mul_en;
        logic emit;
        logic empty;
    } scale_ctl_t;

endpackage

FILE: rtl/cdfts_tbl.sv
// Size and cumulative probability table memories, one write and one read port each.
// Depends on cdfts_pkg.
module cdfts_tbl
    import cdfts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [SIZE_W-1:0] wr_size,
    input  logic [PROB_W-1:0] wr_prob,
    input  logic [AW-1:0]     prob_addr,
    input  logic [AW-1:0]     size_addr,
    output logic [PROB_W-1:0] prob_rdata,
    output logic [SIZE_W-1:0] size_rdata
);

    logic [SIZE_W-1:0] size_mem [TABLE_DEPTH];
    logic [PROB_W-1:0] prob_mem [TABLE_DEPTH];
    logic [PROB_W-1:0] prob_rdata_reg;
    logic [SIZE_W-1:0] size_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            size_mem[wr_addr] <= wr_size;
        end
        size_rdata_reg <= size_mem[size_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prob_mem[wr_addr] <= wr_prob;
        end
        prob_rdata_reg <= prob_mem[prob_addr];
    end

    assign prob_rdata = prob_rdata_reg;
    assign size_rdata = size_rdata_reg;

endmodule

FILE: rtl/cdfts_ctrl.sv
// Search sequencer: binary search over the probability table with one shared comparator.
// Depends on cdfts_pkg.
module cdfts_ctrl
    import cdfts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              operation,
    input  logic [PROB_W-1:0] uniform_value,
    input  logic [CNT_W-1:0]  entries_in_use,
    input  logic [PROB_W-1:0] prob_rdata,
    output logic              busy,
    output logic [AW-1:0]     prob_addr,
    output logic [AW-1:0]     size_addr,
    output scale_ctl_t        scale_ctl
);

    state_t            state_reg, state_next;
    logic [AW-1:0]     lo_reg, lo_next;
    logic [AW-1:0]     hi_reg, hi_next;
    logic [AW-1:0]     mid_reg, mid_next;
    logic [PROB_W-1:0] u_reg, u_next;
    logic [CW-1:0]     cnt_clamp;
    logic [AW:0]       mid_sum;
    logic [AW-1:0]     mid_calc;
    logic              accept_sample;
    logic              cnt_zero;

    assign cnt_clamp = (32'(entries_in_use) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                 : CW'(entries_in_use);
    assign cnt_zero      = (entries_in_use == '0);
    assign accept_sample = start && (state_reg == ST_IDLE) && (operation == OP_SAMPLE);
    assign mid_sum       = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc      = mid_sum[AW:1];

    assign prob_addr = mid_calc;
    assign size_addr = hi_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_sample && !cnt_zero)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:  state_next = (lo_reg < hi_reg) ? ST_CMP : ST_FETCH;
            ST_CMP:    state_next = ST_PROBE;
            ST_FETCH:  state_next = ST_MUL;
            ST_MUL:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        mid_next = mid_reg;
        u_next   = u_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_sample)
                begin
                    u_next  = uniform_value;
                    lo_next = '0;
                    hi_next = AW'(cnt_clamp - CW'(1));
                end
            end
            ST_PROBE:
            begin
                mid_next = mid_calc;
            end
            ST_CMP:
            begin
                // first slot whose cumulative probability covers the draw
                if (u_reg <= prob_rdata)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        busy              = (state_reg != ST_IDLE);
        scale_ctl.mul_en  = (state_reg == ST_FETCH);
        scale_ctl.emit    = (state_reg == ST_MUL) || (accept_sample && cnt_zero);
        scale_ctl.empty   = (state_reg == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        u_reg   <= u_next;
    end

endmodule

FILE: rtl/cdfts_scale.sv
// Packet scaling and saturation stage, holds the result beat registers.
// Depends on cdfts_pkg.
module cdfts_scale
    import cdfts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  scale_ctl_t        scale_ctl,
    input  logic [SIZE_W-1:0] size_rdata,
    input  logic              scale_by_packet,
    input  logic [BPP_W-1:0]  bytes_per_packet,
    output logic              done,
    output logic [MSG_W-1:0]  msg_size,
    output logic              table_empty
);

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MSG_W-1:0]  msg_size_reg, msg_size_next;
    logic              empty_reg;
    logic              done_reg;

    always_comb
    begin
        prod_next = scale_by_packet ? (PROD_W'(size_rdata) * PROD_W'(bytes_per_packet))
                                    : PROD_W'(size_rdata);
        if (scale_ctl.empty)
        begin
            msg_size_next = '0;
        end
        else if (prod_reg > PROD_W'(MSG_MAX))
        begin
            msg_size_next = MSG_MAX;
        end
        else
        begin
            msg_size_next = prod_reg[MSG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (scale_ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (scale_ctl.emit)
        begin
            msg_size_reg <= msg_size_next;
            empty_reg    <= scale_ctl.empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= scale_ctl.emit;
        end
    end

    assign done        = done_reg;
    assign msg_size    = msg_size_reg;
    assign table_empty = empty_reg;

endmodule

FILE: rtl/cdf_table_size_sampler_top.sv
// Top level of the CDF table size sampler: config registers, table, sequencer, scaling.
// Depends on cdfts_pkg, cdfts_tbl, cdfts_ctrl and cdfts_scale.
//
// A beat is taken when start is high and busy is low. A load beat writes one table slot in
// that cycle and gives no result. A sample beat runs a binary search over the slots in use,
// one memory probe and one compare per iteration, then a size read and a multiply; the result
// beat is shown with done for one cycle as busy falls, so a new beat may start in that same
// cycle. The probe-compare loop through the table memory read port sets how long busy stays
// high. An empty table gives its result the cycle after the beat. Results cannot be held off
// by the receiver.
module cdf_table_size_sampler_top
    import cdfts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  operation,
    input  logic [IDX_W-1:0]      entry_index,
    input  logic [SIZE_W-1:0]     entry_size,
    input  logic [PROB_W-1:0]     entry_cum_prob,
    input  logic [PROB_W-1:0]     uniform_value,
    output logic                  done,
    output logic [MSG_W-1:0]      msg_size,
    output logic                  table_empty,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [CNT_W-1:0]  entries_in_use_reg;
    logic              scale_by_packet_reg;
    logic [BPP_W-1:0]  bytes_per_packet_reg;
    logic              wr_en;
    logic [AW-1:0]     prob_addr;
    logic [AW-1:0]     size_addr;
    logic [PROB_W-1:0] prob_rdata;
    logic [SIZE_W-1:0] size_rdata;
    scale_ctl_t        scale_ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg   <= '0;
            scale_by_packet_reg  <= 1'b0;
            bytes_per_packet_reg <= BPP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENTRIES_IN_USE:   entries_in_use_reg   <= CNT_W'(cfg_wdata);
                CFG_SCALE_BY_PACKET:  scale_by_packet_reg  <= cfg_wdata[0];
                CFG_BYTES_PER_PACKET: bytes_per_packet_reg <= cfg_wdata[BPP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // slots at or beyond the table depth are dropped
    assign wr_en = start && !busy && (operation == OP_LOAD)
                   && (32'(entry_index) < 32'(TABLE_DEPTH));

    cdfts_tbl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_tbl (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (AW'(entry_index)),
        .wr_size    (entry_size),
        .wr_prob    (entry_cum_prob),
        .prob_addr  (prob_addr),
        .size_addr  (size_addr),
        .prob_rdata (prob_rdata),
        .size_rdata (size_rdata)
    );

    cdfts_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .operation      (operation),
        .uniform_value  (uniform_value),
        .entries_in_use (entries_in_use_reg),
        .prob_rdata     (prob_rdata),
        .busy           (busy),
        .prob_addr      (prob_addr),
        .size_addr      (size_addr),
        .scale_ctl      (scale_ctl)
    );

    cdfts_scale u_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .scale_ctl        (scale_ctl),
        .size_rdata       (size_rdata),
        .scale_by_packet  (scale_by_packet_reg),
        .bytes_per_packet (bytes_per_packet_reg),
        .done             (done),
        .msg_size         (msg_size),
        .table_empty      (table_empty)
    );

endmodule

FILE: rtl/cdfts_checker.sv
// Port-level checks for the CDF table size sampler, bound to the top level.
// Depends on cdfts_pkg and cdf_table_size_sampler_top.
module cdfts_checker
    import cdfts_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             operation,
    input logic             done,
    input logic [MSG_W-1:0] msg_size,
    input logic             table_empty
);

    logic accept;

    assign accept = start && !busy;

    a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_empty) |-> (msg_size == '0))
        else $error("empty table result with non-zero size");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == OP_LOAD)) |=> !done && !busy)
        else $error("load beat produced a result or stalled");

    a_sample_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == OP_SAMPLE)) |=> (busy || (done && table_empty)))
        else $error("sample beat neither searching nor answered empty");

endmodule

bind cdf_table_size_sampler_top cdfts_checker u_cdfts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .done        (done),
    .msg_size    (msg_size),
    .table_empty (table_empty)
);

FILE: tb/sv/cdf_table_size_sampler_top_test.sv
`timescale 1ns / 1ps
// Self-checking test of cdf_table_size_sampler_top: table loads, inverse-CDF draws, packet scaling.
// Depends on cdfts_pkg and the sampler RTL; keeps its own copy of the table and registers.
module cdf_table_size_sampler_top_test;
    import cdfts_pkg::*;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int ITEMS = 1750;
    localparam int STALL_LIMIT = 2000;
    localparam int LOAD_TAIL = 25;
    localparam int TAIL = 30;
    localparam logic [PROB_W-1:0] PROB_ONE = 33'h1_0000_0000;
    localparam logic [PROB_W-1:0] PROB_TOP = '1;

    typedef struct packed {
        logic [MSG_W-1:0] msg_size;
        logic             table_empty;
    } draw_result_t;

    typedef struct {
        int unsigned       idx;
        logic [SIZE_W-1:0] sz;
        logic [PROB_W-1:0] cp;
    } slot_entry_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    op_t                   operation = OP_LOAD;
    logic [IDX_W-1:0]      entry_index = '0;
    logic [SIZE_W-1:0]     entry_size = '0;
    logic [PROB_W-1:0]     entry_cum_prob = '0;
    logic [PROB_W-1:0]     uniform_value = '0;
    logic                  done;
    logic [MSG_W-1:0]      msg_size;
    logic                  table_empty;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // shadow of the block's table and registers
    logic [SIZE_W-1:0] size_mem [DEPTH];
    logic [PROB_W-1:0] prob_mem [DEPTH];
    logic [CNT_W-1:0]  entries_reg = '0;
    logic              scale_reg = 1'b0;
    logic [BPP_W-1:0]  bpp_reg = BPP_RESET;

    draw_result_t pending_draws[$];
    draw_result_t oldest_draw;
    int unsigned  errors = 0;
    int unsigned  items_sent = 0;
    int unsigned  idle_cycles = 0;
    bit           steady = 1'b0;

    cdf_table_size_sampler_top #(.TABLE_DEPTH(DEPTH)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .entry_index    (entry_index),
        .entry_size     (entry_size),
        .entry_cum_prob (entry_cum_prob),
        .uniform_value  (uniform_value),
        .done           (done),
        .msg_size       (msg_size),
        .table_empty    (table_empty),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic draw_result_t predict_draw(logic [PROB_W-1:0] u);
        int unsigned        count;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        mid;
        logic [PROD_W-1:0]  product;
        draw_result_t       r;
        count = (entries_reg > DEPTH) ? DEPTH : entries_reg;
        r.msg_size = '0;
        r.table_empty = 1'b1;
        if (count != 0)
        begin
            lo = 0;
            hi = count - 1;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (u <= prob_mem[mid])
                    hi = mid;
                else
                    lo = mid + 1;
            end
            product = PROD_W'(size_mem[hi]);
            if (scale_reg)
            begin
                product = PROD_W'(size_mem[hi]) * PROD_W'(bpp_reg);
                if (product > PROD_W'(MSG_MAX))
                    product = PROD_W'(MSG_MAX);
            end
            r.msg_size = product[MSG_W-1:0];
            r.table_empty = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [PROB_W-1:0] rand_prob();
        return {$urandom_range(0, 1) == 1, $urandom()};
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        if ($urandom_range(0, 9) < 3)
            return SIZE_W'($urandom_range(0, 4095));
        return SIZE_W'($urandom());
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // draws cluster on table boundaries, with extremes and plain noise
    function automatic logic [PROB_W-1:0] pick_uniform(int unsigned count);
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, (count == 0) ? DEPTH - 1 : count - 1);
        if (r < 35)
            return prob_mem[k];
        if (r < 50)
            return ($urandom_range(0, 1) == 1) ? prob_mem[k] + 1'b1 : prob_mem[k] - 1'b1;
        if (r < 80)
            return {1'b0, $urandom()};
        if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return PROB_ONE;
                2: return PROB_TOP;
                default: return PROB_ONE + 1'b1;
            endcase
        end
        return rand_prob();
    endfunction

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        errors++;
        if (errors < 100)
            $display("%0t: %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    task automatic send_beat(op_t op, logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] sz,
                             logic [PROB_W-1:0] cp, logic [PROB_W-1:0] u);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        operation = op;
        entry_index = idx;
        entry_size = sz;
        entry_cum_prob = cp;
        uniform_value = u;
        do @(posedge clk); while (busy);
        items_sent++;
        if (op == OP_LOAD)
        begin
            size_mem[idx] = sz;
            prob_mem[idx] = cp;
        end
        else
            pending_draws.insert(pending_draws.size(), predict_draw(u));
    endtask

    task automatic load_slot(int unsigned idx, logic [SIZE_W-1:0] sz, logic [PROB_W-1:0] cp);
        send_beat(OP_LOAD, IDX_W'(idx), sz, cp, rand_prob());
    endtask

    task automatic draw(logic [PROB_W-1:0] u);
        send_beat(OP_SAMPLE, IDX_W'($urandom()), SIZE_W'($urandom()), rand_prob(), u);
    endtask

    // drop start and wait until the block is quiet; a load leaves no result behind
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (busy || pending_draws.size() != 0) @(negedge clk);
        repeat (LOAD_TAIL) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_ENTRIES_IN_USE:   entries_reg = data[CNT_W-1:0];
            CFG_SCALE_BY_PACKET:  scale_reg = data[0];
            CFG_BYTES_PER_PACKET: bpp_reg = data[BPP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_empty_table();
        draw('0);
        draw(PROB_ONE);
        draw(PROB_TOP);
    endtask

    task automatic test_search_edges();
        load_slot(0, 24'h000000, 33'h0_0000_0000);
        load_slot(1, 24'hFFFFFF, 33'h0_4000_0000);
        load_slot(2, 24'h123456, 33'h0_8000_0000);
        load_slot(3, 24'hABCDEF, PROB_ONE);
        settle();
        write_reg(CFG_ENTRIES_IN_USE, 16'd4);
        draw('0);
        draw(33'h0_0000_0001);
        draw(33'h0_8000_0000);
        draw(33'h0_8000_0001);
        draw(PROB_ONE);
        draw(PROB_TOP);
        settle();
        write_reg(CFG_ENTRIES_IN_USE, 16'd1);
        draw(PROB_TOP);
    endtask

    task automatic test_irregular_table();
        load_slot(0, 24'h000111, 33'h0_9000_0000);
        load_slot(1, 24'h000222, 33'h0_1000_0000);
        load_slot(2, 24'h000333, 33'h0_5000_0000);
        settle();
        write_reg(CFG_ENTRIES_IN_USE, 16'd3);
        draw(33'h0_2000_0000);
        draw(33'h0_0800_0000);
        settle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        draw(33'h0_0800_0000);
    endtask

    task automatic test_packet_scaling();
        settle();
        write_reg(CFG_SCALE_BY_PACKET, 16'd1);
        draw(33'h0_0800_0000);
        load_slot(0, 24'hFFFFFF, 33'h0_9000_0000);
        settle();
        write_reg(CFG_BYTES_PER_PACKET, 16'hFFFF);
        draw(33'h0_0800_0000);
        settle();
        write_reg(CFG_BYTES_PER_PACKET, 16'd0);
        draw(33'h0_0800_0000);
        settle();
        write_reg(CFG_BYTES_PER_PACKET, 16'd1);
        draw(33'h0_0800_0000);
        settle();
        write_reg(CFG_SCALE_BY_PACKET, 16'hFFFE);
        draw(33'h0_0800_0000);
    endtask

    task automatic test_full_depth();
        longint unsigned level;
        int unsigned     i;
        level = 0;
        for (i = 0; i < DEPTH; i++)
        begin
            level += $urandom_range(0, 8388608);
            if (level > PROB_ONE || (i == DEPTH - 1 && $urandom_range(0, 1) == 1))
                level = PROB_ONE;
            load_slot(i, SIZE_W'($urandom()), PROB_W'(level));
        end
        settle();
        write_reg(CFG_ENTRIES_IN_USE, 16'd2047);
        draw('0);
        draw(PROB_ONE);
        draw(PROB_TOP);
        draw(prob_mem[DEPTH - 1]);
        settle();
        write_reg(CFG_ENTRIES_IN_USE, 16'hFC00);
        draw(prob_mem[DEPTH / 2]);
        draw(PROB_TOP);
    endtask

    task automatic random_round(int unsigned want);
        int unsigned       count;
        int unsigned       n;
        int unsigned       j;
        int unsigned       k;
        bit                irregular;
        slot_entry_t       saved[$];
        slot_entry_t       s;
        logic [PROB_W-1:0] lo_p;
        logic [PROB_W-1:0] hi_p;
        logic [PROB_W-1:0] cp;
        logic [BPP_W-1:0]  bpp;
        longint unsigned   span;
        settle();
        write_reg(CFG_ENTRIES_IN_USE, {5'($urandom()), CNT_W'(want)});
        write_reg(CFG_SCALE_BY_PACKET, {15'($urandom()), $urandom_range(0, 1) == 1});
        case ($urandom_range(0, 9))
            0: bpp = '0;
            1: bpp = 16'd1;
            2: bpp = '1;
            3, 4: bpp = BPP_W'($urandom_range(2, 127));
            default: bpp = BPP_W'($urandom());
        endcase
        write_reg(CFG_BYTES_PER_PACKET, bpp);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
        count = (want > DEPTH) ? DEPTH : want;
        irregular = $urandom_range(0, 3) == 0;
        steady = $urandom_range(0, 4) == 0;
        n = $urandom_range(30, 70);
        for (j = 0; j < n; j++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                k = $urandom_range(0, (count == 0) ? DEPTH - 1 : count - 1);
                if (irregular)
                begin
                    s.idx = k;
                    s.sz = size_mem[k];
                    s.cp = prob_mem[k];
                    saved.insert(saved.size(), s);
                    load_slot(k, rand_size(), rand_prob());
                end
                else
                begin
                    // keep the table ordered: the new value lies between its neighbours where they allow it
                    lo_p = (k == 0) ? '0 : prob_mem[k - 1];
                    hi_p = (k == DEPTH - 1) ? PROB_ONE : prob_mem[k + 1];
                    cp = prob_mem[k];
                    if (lo_p <= hi_p)
                    begin
                        span = longint'(hi_p - lo_p) + 1;
                        cp = lo_p + PROB_W'({$urandom(), $urandom()} % span);
                    end
                    load_slot(k, rand_size(), cp);
                end
            end
            else
                draw(pick_uniform(count));
            if ($urandom_range(0, 49) == 0)
                settle();
        end
        while (saved.size() != 0)
        begin
            s = saved.pop_back();
            load_slot(s.idx, s.sz, s.cp);
        end
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        int unsigned r;
        int unsigned want;
        r = 0;
        while (items_sent < ITEMS)
        begin
            case (r % 8)
                0: want = $urandom_range(1, 16);
                1: want = DEPTH;
                2: want = 1;
                3: want = 2;
                4: want = $urandom_range(17, 300);
                5: want = 2047;
                6: want = 0;
                default: want = $urandom_range(3, 2047);
            endcase
            random_round(want);
            r++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_draws.size() == 0)
                report_mismatch("result with no draw pending", 0, msg_size);
            else
            begin
                oldest_draw = pending_draws.pop_front();
                if (msg_size !== oldest_draw.msg_size)
                    report_mismatch("msg_size", oldest_draw.msg_size, msg_size);
                if (table_empty !== oldest_draw.table_empty)
                    report_mismatch("table_empty", oldest_draw.table_empty, table_empty);
            end
        end
    end

    // stall watchdog: any beat, result or register write counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            size_mem[i] = '0;
            prob_mem[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_empty_table();
        test_search_edges();
        test_irregular_table();
        test_packet_scaling();
        test_full_depth();
        test_random_traffic();
        settle();
        repeat (TAIL) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
